// ----- rtl/pwqcb_pkg.sv -----
package pwqcb_pkg;

  localparam int MAX_TASKS_DEF   = 16;
  localparam int MAX_LEVEL_DEF   = 3;
  localparam int COOKIE_BITS_DEF = 16;

  localparam int ACT_W       = 2;
  localparam int SLOT_W      = 4;
  localparam int PRIO_W      = 2;
  localparam int IN_COOKIE_W = 16;
  localparam int LEN_W       = 5;
  localparam int MAXP_W      = 2;
  localparam int BATCH_W     = 8;
  localparam int CREDIT_W    = 7;
  localparam int CFG_IDX_W   = 1;
  localparam int CFG_DATA_W  = 8;
  localparam int WALL_CAP    = 16;
  localparam int RST_MAXP    = 2;
  localparam int RST_BATCH   = 16;

  typedef enum logic [ACT_W-1:0] {
    ACT_ENQ  = 2'd0,
    ACT_NEXT = 2'd1,
    ACT_WAKE = 2'd2,
    ACT_ALL  = 2'd3
  } action_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MAXP  = 1'b0,
    CFG_BATCH = 1'b1
  } cfg_idx_t;

  typedef enum logic [2:0] {
    B_IDLE,
    B_ENQ_SCAN,
    B_ENQ_GRP,
    B_PICK_SCAN,
    B_WALL,
    B_REM_INIT,
    B_REM_FIND,
    B_REM_GRP
  } bstate_t;

  typedef struct packed {
    action_t action;
    logic    slot_ok;
    logic    swp;
  } cmd_ctl_t;

  function automatic logic [MAXP_W-1:0] eff_max(input logic [MAXP_W-1:0] maxp,
                                                input logic [MAXP_W-1:0] top);
    return (maxp > top) ? top : maxp;
  endfunction

endpackage

// ----- rtl/pwqcb_front.sv -----
module pwqcb_front import pwqcb_pkg::*; #(
  parameter int MAX_TASKS   = MAX_TASKS_DEF,
  parameter int MAX_LEVEL   = MAX_LEVEL_DEF,
  parameter int COOKIE_BITS = COOKIE_BITS_DEF,
  localparam int IW = $clog2(MAX_TASKS),
  localparam int LW = $clog2(MAX_LEVEL + 1)
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    start,
  output logic                    busy,
  input  logic [ACT_W-1:0]        in_action,
  input  logic [SLOT_W-1:0]       in_task_slot,
  input  logic [PRIO_W-1:0]       in_priority_req,
  input  logic [IN_COOKIE_W-1:0]  in_owner_cookie,
  input  logic                    in_swapper,
  input  logic [MAXP_W-1:0]       max_priority,
  output logic                    cmd_valid,
  input  logic                    cmd_pop,
  output cmd_ctl_t                cmd_ctl,
  output logic [IW-1:0]           cmd_slot,
  output logic [LW-1:0]           cmd_lvl,
  output logic [COOKIE_BITS-1:0]  cmd_cookie
);

  cmd_ctl_t               ctl_r    [2];
  logic [IW-1:0]          slot_r   [2];
  logic [LW-1:0]          lvl_r    [2];
  logic [COOKIE_BITS-1:0] cookie_r [2];
  logic                   wptr_r, rptr_r;
  logic [1:0]             cnt_r;

  logic [MAXP_W-1:0] maxl;
  logic [MAXP_W-1:0] lvl_c;
  logic              push;
  cmd_ctl_t          ctl_c;

  assign busy = (cnt_r == 2'd2);
  assign push = start && !busy;
  assign maxl = eff_max(max_priority, MAXP_W'(MAX_LEVEL));

  always_comb begin
    if (maxl == '0) begin
      lvl_c = '0;
    end else begin
      lvl_c = (in_priority_req > maxl) ? maxl : in_priority_req;
    end
    ctl_c.action  = action_t'(in_action);
    ctl_c.slot_ok = (32'(in_task_slot) < MAX_TASKS);
    ctl_c.swp     = in_swapper;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= 1'b0;
      rptr_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      if (push) begin
        wptr_r <= ~wptr_r;
      end
      if (cmd_pop) begin
        rptr_r <= ~rptr_r;
      end
      cnt_r <= cnt_r + 2'(push) - 2'(cmd_pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      ctl_r[wptr_r]    <= ctl_c;
      slot_r[wptr_r]   <= IW'(in_task_slot);
      lvl_r[wptr_r]    <= LW'(lvl_c);
      cookie_r[wptr_r] <= COOKIE_BITS'(in_owner_cookie);
    end
  end

  assign cmd_valid  = (cnt_r != 2'd0);
  assign cmd_ctl    = ctl_r[rptr_r];
  assign cmd_slot   = slot_r[rptr_r];
  assign cmd_lvl    = lvl_r[rptr_r];
  assign cmd_cookie = cookie_r[rptr_r];

endmodule

// ----- rtl/pwqcb_back.sv -----
module pwqcb_back import pwqcb_pkg::*; #(
  parameter int MAX_TASKS   = MAX_TASKS_DEF,
  parameter int MAX_LEVEL   = MAX_LEVEL_DEF,
  parameter int COOKIE_BITS = COOKIE_BITS_DEF,
  localparam int IW = $clog2(MAX_TASKS),
  localparam int LW = $clog2(MAX_LEVEL + 1),
  localparam int NL = MAX_LEVEL + 1,
  localparam int CW = $clog2(MAX_TASKS + 1)
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic [MAXP_W-1:0]       max_priority,
  input  logic [BATCH_W-1:0]      batch_count,
  input  logic                    cmd_valid,
  output logic                    cmd_pop,
  input  cmd_ctl_t                cmd_ctl,
  input  logic [IW-1:0]           cmd_slot,
  input  logic [LW-1:0]           cmd_lvl,
  input  logic [COOKIE_BITS-1:0]  cmd_cookie,
  output logic                    o_valid,
  output logic                    o_woken_valid,
  output logic [IW-1:0]           o_slot,
  output logic                    o_last,
  output logic                    o_error,
  output logic [CW-1:0]           o_len
);

  localparam logic [LW-1:0] RST_LVL =
    LW'(eff_max(MAXP_W'(RST_MAXP), MAXP_W'(MAX_LEVEL)));

  bstate_t state_r, state_nxt;
  cmd_ctl_t ctl_r, ctl_nxt;
  logic [IW-1:0] slot_r, slot_nxt, walk_r, walk_nxt, prev_r, prev_nxt, tgt_r, tgt_nxt;
  logic prev_v_r, prev_v_nxt, wall_r, wall_nxt;
  logic [LW-1:0] lvl_r, lvl_nxt, scan_q_r, scan_q_nxt, scan_org_r, scan_org_nxt;
  logic [LW-1:0] wall_lvl_r, wall_lvl_nxt, cur_level_r, cur_level_nxt;
  logic [LW:0] scan_i_r, scan_i_nxt;
  logic [COOKIE_BITS-1:0] ck_r, ck_nxt, cur_cookie_r, cur_cookie_nxt;
  logic [LEN_W-1:0] wall_n_r, wall_n_nxt;
  logic [CW-1:0] fin_len_r, fin_len_nxt, count_r, count_nxt;
  logic [BATCH_W-1:0] batch_left_r, batch_left_nxt;
  logic [CREDIT_W-1:0] credit_r, credit_nxt;

  logic                   slot_queued_r [MAX_TASKS], slot_queued_nxt [MAX_TASKS];
  logic [LW-1:0]          slot_level_r [MAX_TASKS], slot_level_nxt [MAX_TASKS];
  logic [COOKIE_BITS-1:0] slot_cookie_r [MAX_TASKS], slot_cookie_nxt [MAX_TASKS];
  logic [IW-1:0]          slot_next_link_r [MAX_TASKS], slot_next_link_nxt [MAX_TASKS];
  logic                   shas_r [MAX_TASKS], shas_nxt [MAX_TASKS];
  logic                   ishead_r [MAX_TASKS], ishead_nxt [MAX_TASKS];
  logic [IW-1:0]          group_next_link_r [MAX_TASKS], group_next_link_nxt [MAX_TASKS];
  logic                   ghas_r [MAX_TASKS], ghas_nxt [MAX_TASKS];
  logic [IW-1:0]          lv_head_r [NL], lv_head_nxt [NL];
  logic [IW-1:0]          lv_tail_r [NL], lv_tail_nxt [NL];
  logic                   lv_valid_r [NL], lv_valid_nxt [NL];

  logic [LW-1:0] maxl;
  assign maxl = LW'(eff_max(max_priority, MAXP_W'(MAX_LEVEL)));
  assign cmd_pop = (state_r == B_IDLE) && cmd_valid;

  always_comb begin
    logic [IW-1:0] s, h, t, m;
    logic [LW-1:0] l, q;
    logic [BATCH_W-1:0] bl;
    logic [CREDIT_W-1:0] cr;
    logic [LW:0] i;
    logic [LEN_W-1:0] n;
    logic go_scan, go_rem, rem_fin, do_app, em, em_wv, em_last, em_err, wlast;
    logic [IW-1:0] rem_x, app_s;
    logic [LW-1:0] app_l;
    logic [CW-1:0] em_len;

    state_nxt = state_r;
    ctl_nxt = ctl_r;
    slot_nxt = slot_r;
    walk_nxt = walk_r;
    prev_nxt = prev_r;
    prev_v_nxt = prev_v_r;
    tgt_nxt = tgt_r;
    wall_nxt = wall_r;
    lvl_nxt = lvl_r;
    scan_q_nxt = scan_q_r;
    scan_org_nxt = scan_org_r;
    scan_i_nxt = scan_i_r;
    wall_lvl_nxt = wall_lvl_r;
    cur_level_nxt = cur_level_r;
    ck_nxt = ck_r;
    cur_cookie_nxt = cur_cookie_r;
    wall_n_nxt = wall_n_r;
    fin_len_nxt = fin_len_r;
    count_nxt = count_r;
    batch_left_nxt = batch_left_r;
    credit_nxt = credit_r;
    slot_queued_nxt = slot_queued_r;
    slot_level_nxt = slot_level_r;
    slot_cookie_nxt = slot_cookie_r;
    slot_next_link_nxt = slot_next_link_r;
    shas_nxt = shas_r;
    ishead_nxt = ishead_r;
    group_next_link_nxt = group_next_link_r;
    ghas_nxt = ghas_r;
    lv_head_nxt = lv_head_r;
    lv_tail_nxt = lv_tail_r;
    lv_valid_nxt = lv_valid_r;

    s = '0; h = '0; t = '0; m = '0; l = '0; q = '0; bl = '0; cr = '0; i = '0; n = '0;
    go_scan = 1'b0; go_rem = 1'b0; rem_fin = 1'b0; do_app = 1'b0;
    em = 1'b0; em_wv = 1'b0; em_last = 1'b1; em_err = 1'b0; wlast = 1'b0;
    rem_x = '0; app_s = '0; app_l = '0; em_len = count_r;

    case (state_r)
      B_IDLE: begin
        if (cmd_valid) begin
          ctl_nxt = cmd_ctl;
          slot_nxt = cmd_slot;
          lvl_nxt = cmd_lvl;
          ck_nxt = cmd_cookie;
          wall_nxt = 1'b0;
          s = cmd_slot;
          case (cmd_ctl.action)
            ACT_ENQ: begin
              if (!cmd_ctl.slot_ok) begin
                em = 1'b1;
              end else if (slot_queued_r[s]) begin
                em = 1'b1;
                em_err = 1'b1;
              end else begin
                slot_queued_nxt[s] = 1'b1;
                slot_cookie_nxt[s] = cmd_cookie;
                ghas_nxt[s] = 1'b0;
                slot_level_nxt[s] = cmd_lvl;
                count_nxt = count_r + CW'(1);
                em_len = count_r + CW'(1);
                if (maxl == '0 && cmd_ctl.swp) begin
                  ishead_nxt[s] = 1'b1;
                  if (lv_valid_r[0]) begin
                    slot_next_link_nxt[s] = lv_head_r[0];
                    shas_nxt[s] = 1'b1;
                  end else begin
                    shas_nxt[s] = 1'b0;
                    lv_tail_nxt[0] = s;
                    lv_valid_nxt[0] = 1'b1;
                  end
                  lv_head_nxt[0] = s;
                  em = 1'b1;
                end else if (maxl == '0 || !lv_valid_r[cmd_lvl]) begin
                  do_app = 1'b1;
                  app_l = cmd_lvl;
                  app_s = s;
                  em = 1'b1;
                end else begin
                  walk_nxt = lv_head_r[cmd_lvl];
                  state_nxt = B_ENQ_SCAN;
                end
              end
            end
            ACT_NEXT: begin
              if (maxl == '0) begin
                if (lv_valid_r[0]) begin
                  go_rem = 1'b1;
                  rem_x = lv_head_r[0];
                end else begin
                  em = 1'b1;
                end
              end else begin
                l = cur_level_r;
                go_scan = 1'b1;
                if (lv_valid_r[l]) begin
                  t = lv_head_r[l];
                  if (cur_cookie_r == slot_cookie_r[t]) begin
                    bl = batch_left_r - BATCH_W'(1);
                    batch_left_nxt = bl;
                    if (bl != '0) begin
                      go_scan = 1'b0;
                      go_rem = 1'b1;
                      rem_x = t;
                    end else if (t != lv_tail_r[l]) begin
                      lv_head_nxt[l] = slot_next_link_r[t];
                      shas_nxt[t] = 1'b0;
                      slot_next_link_nxt[lv_tail_r[l]] = t;
                      shas_nxt[lv_tail_r[l]] = 1'b1;
                      lv_tail_nxt[l] = t;
                    end
                  end
                  if (go_scan) begin
                    cr = credit_r - CREDIT_W'(1);
                    credit_nxt = cr;
                    if (cr != '0) begin
                      cur_cookie_nxt = slot_cookie_r[t];
                      batch_left_nxt = batch_count;
                      go_scan = 1'b0;
                      go_rem = 1'b1;
                      rem_x = t;
                    end
                  end
                end
                if (go_scan) begin
                  scan_org_nxt = l;
                  scan_q_nxt = l;
                  scan_i_nxt = '0;
                  state_nxt = B_PICK_SCAN;
                end
              end
            end
            ACT_WAKE: begin
              if (cmd_ctl.slot_ok && slot_queued_r[s]) begin
                go_rem = 1'b1;
                rem_x = s;
              end else begin
                em = 1'b1;
              end
            end
            default: begin
              if (count_r == '0) begin
                em = 1'b1;
              end else begin
                fin_len_nxt = (32'(count_r) > WALL_CAP) ? count_r - CW'(WALL_CAP) : '0;
                wall_nxt = 1'b1;
                wall_n_nxt = '0;
                wall_lvl_nxt = LW'(MAX_LEVEL);
                state_nxt = B_WALL;
              end
            end
          endcase
        end
      end

      B_ENQ_SCAN: begin
        h = walk_r;
        if (slot_cookie_r[h] == ck_r) begin
          state_nxt = B_ENQ_GRP;
        end else if (!shas_r[h]) begin
          do_app = 1'b1;
          app_l = lvl_r;
          app_s = slot_r;
          em = 1'b1;
        end else begin
          walk_nxt = slot_next_link_r[h];
        end
      end

      B_ENQ_GRP: begin
        t = walk_r;
        if (ghas_r[t]) begin
          walk_nxt = group_next_link_r[t];
        end else begin
          group_next_link_nxt[t] = slot_r;
          ghas_nxt[t] = 1'b1;
          ishead_nxt[slot_r] = 1'b0;
          shas_nxt[slot_r] = 1'b0;
          em = 1'b1;
        end
      end

      B_PICK_SCAN: begin
        q = (scan_q_r == '0) ? maxl : scan_q_r - LW'(1);
        i = scan_i_r + (LW+1)'(1);
        scan_q_nxt = q;
        scan_i_nxt = i;
        if (lv_valid_r[q]) begin
          cur_level_nxt = q;
          credit_nxt = CREDIT_W'(1) << {q, 1'b0};
          cur_cookie_nxt = slot_cookie_r[lv_head_r[q]];
          batch_left_nxt = batch_count;
          go_rem = 1'b1;
          rem_x = lv_head_r[q];
        end else if (q == scan_org_r || 32'(i) == NL) begin
          cur_level_nxt = maxl;
          credit_nxt = CREDIT_W'(1) << {maxl, 1'b0};
          cur_cookie_nxt = '0;
          batch_left_nxt = batch_count;
          em = 1'b1;
        end
      end

      B_WALL: begin
        if (lv_valid_r[wall_lvl_r]) begin
          go_rem = 1'b1;
          rem_x = lv_head_r[wall_lvl_r];
        end else begin
          wall_lvl_nxt = wall_lvl_r - LW'(1);
        end
      end

      B_REM_INIT: begin
        walk_nxt = lv_head_r[slot_level_r[tgt_r]];
        prev_v_nxt = 1'b0;
        state_nxt = B_REM_FIND;
      end

      B_REM_FIND: begin
        s = tgt_r;
        l = slot_level_r[s];
        h = walk_r;
        if (ishead_r[s]) begin
          if (h == s) begin
            rem_fin = 1'b1;
            if (ghas_r[s]) begin
              m = group_next_link_r[s];
              ishead_nxt[m] = 1'b1;
              slot_next_link_nxt[m] = slot_next_link_r[s];
              shas_nxt[m] = shas_r[s];
              if (!prev_v_r) begin
                lv_head_nxt[l] = m;
              end else begin
                slot_next_link_nxt[prev_r] = m;
              end
              if (lv_tail_r[l] == s) begin
                lv_tail_nxt[l] = m;
              end
            end else begin
              if (!prev_v_r) begin
                if (shas_r[s]) begin
                  lv_head_nxt[l] = slot_next_link_r[s];
                end else begin
                  lv_valid_nxt[l] = 1'b0;
                end
              end else begin
                slot_next_link_nxt[prev_r] = slot_next_link_r[s];
                shas_nxt[prev_r] = shas_r[s];
                if (lv_tail_r[l] == s) begin
                  lv_tail_nxt[l] = prev_r;
                end
              end
            end
          end else begin
            prev_nxt = h;
            prev_v_nxt = 1'b1;
            walk_nxt = slot_next_link_r[h];
          end
        end else if (slot_cookie_r[h] == slot_cookie_r[s]) begin
          prev_nxt = h;
          state_nxt = B_REM_GRP;
        end else begin
          walk_nxt = slot_next_link_r[h];
        end
      end

      B_REM_GRP: begin
        s = tgt_r;
        t = walk_r;
        if (ghas_r[t] && group_next_link_r[t] == s) begin
          group_next_link_nxt[t] = group_next_link_r[s];
          ghas_nxt[t] = ghas_r[s];
          rem_fin = 1'b1;
        end else if (ghas_r[t]) begin
          walk_nxt = group_next_link_r[t];
        end else begin
          walk_nxt = slot_next_link_r[prev_r];
          state_nxt = B_REM_FIND;
        end
      end

      default: begin
        state_nxt = B_IDLE;
      end
    endcase

    if (do_app) begin
      ishead_nxt[app_s] = 1'b1;
      shas_nxt[app_s] = 1'b0;
      if (lv_valid_r[app_l]) begin
        slot_next_link_nxt[lv_tail_r[app_l]] = app_s;
        shas_nxt[lv_tail_r[app_l]] = 1'b1;
      end else begin
        lv_head_nxt[app_l] = app_s;
        lv_valid_nxt[app_l] = 1'b1;
      end
      lv_tail_nxt[app_l] = app_s;
    end

    if (go_rem) begin
      tgt_nxt = rem_x;
      state_nxt = B_REM_INIT;
    end

    if (em) begin
      state_nxt = B_IDLE;
    end

    if (rem_fin) begin
      slot_queued_nxt[tgt_r] = 1'b0;
      ishead_nxt[tgt_r] = 1'b0;
      shas_nxt[tgt_r] = 1'b0;
      ghas_nxt[tgt_r] = 1'b0;
      count_nxt = count_r - CW'(1);
      em = 1'b1;
      em_wv = 1'b1;
      if (wall_r) begin
        n = wall_n_r + LEN_W'(1);
        wall_n_nxt = n;
        wlast = (32'(n) == WALL_CAP) || (count_r == CW'(1));
        em_last = wlast;
        em_len = fin_len_r;
        state_nxt = wlast ? B_IDLE : B_WALL;
      end else begin
        em_len = count_r - CW'(1);
        state_nxt = B_IDLE;
      end
    end

    o_valid = em;
    o_woken_valid = em_wv;
    o_slot = em_wv ? tgt_r : '0;
    o_last = em_last;
    o_error = em_err;
    o_len = em_len;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= B_IDLE;
      count_r <= '0;
      cur_level_r <= RST_LVL;
      credit_r <= CREDIT_W'(1) << {RST_LVL, 1'b0};
      cur_cookie_r <= '0;
      batch_left_r <= BATCH_W'(RST_BATCH);
      wall_r <= 1'b0;
      for (int k = 0; k < MAX_TASKS; k++) begin
        slot_queued_r[k] <= 1'b0;
      end
      for (int k = 0; k < NL; k++) begin
        lv_valid_r[k] <= 1'b0;
      end
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      cur_level_r <= cur_level_nxt;
      credit_r <= credit_nxt;
      cur_cookie_r <= cur_cookie_nxt;
      batch_left_r <= batch_left_nxt;
      wall_r <= wall_nxt;
      slot_queued_r <= slot_queued_nxt;
      lv_valid_r <= lv_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ctl_r <= ctl_nxt;
    slot_r <= slot_nxt;
    walk_r <= walk_nxt;
    prev_r <= prev_nxt;
    prev_v_r <= prev_v_nxt;
    tgt_r <= tgt_nxt;
    lvl_r <= lvl_nxt;
    scan_q_r <= scan_q_nxt;
    scan_org_r <= scan_org_nxt;
    scan_i_r <= scan_i_nxt;
    wall_lvl_r <= wall_lvl_nxt;
    ck_r <= ck_nxt;
    wall_n_r <= wall_n_nxt;
    fin_len_r <= fin_len_nxt;
    slot_level_r <= slot_level_nxt;
    slot_cookie_r <= slot_cookie_nxt;
    slot_next_link_r <= slot_next_link_nxt;
    shas_r <= shas_nxt;
    ishead_r <= ishead_nxt;
    group_next_link_r <= group_next_link_nxt;
    ghas_r <= ghas_nxt;
    lv_head_r <= lv_head_nxt;
    lv_tail_r <= lv_tail_nxt;
  end

endmodule

// ----- rtl/priority_wait_queue_cookie_batching.sv -----
// An enqueue walks the level list (level list walk); a wake next scans the levels, then walks
// for the predecessor (level scan, then predecessor walk); a wake-all removes queued tasks
// in turn, up to WALL_CAP, one result per removal. The back sequencer takes a new beat only
// after it has finished the last one. A two-entry command queue takes beats while the back works.
// Results are strobed for one cycle, in the cycle after the back finishes each removal.
// Synchronous reset empties all levels and reloads scan state from the reset constants.
module priority_wait_queue_cookie_batching import pwqcb_pkg::*; #(
  parameter int MAX_TASKS   = MAX_TASKS_DEF,
  parameter int MAX_LEVEL   = MAX_LEVEL_DEF,
  parameter int COOKIE_BITS = COOKIE_BITS_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   start,
  output logic                   busy,
  input  logic [ACT_W-1:0]       in_action,
  input  logic [SLOT_W-1:0]      in_task_slot,
  input  logic [PRIO_W-1:0]      in_priority_req,
  input  logic [IN_COOKIE_W-1:0] in_owner_cookie,
  input  logic                   in_swapper,
  output logic                   out_valid,
  output logic                   out_woken_valid,
  output logic [SLOT_W-1:0]      out_woken_slot,
  output logic                   out_last,
  output logic                   out_error,
  output logic [LEN_W-1:0]       out_queue_length,
  input  logic                   cfg_we,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_wdata
);

  localparam int IW = $clog2(MAX_TASKS);
  localparam int LW = $clog2(MAX_LEVEL + 1);
  localparam int CW = $clog2(MAX_TASKS + 1);

  logic [MAXP_W-1:0]      max_priority_r;
  logic [BATCH_W-1:0]     batch_count_r;
  logic                   cmd_valid, cmd_pop;
  cmd_ctl_t               cmd_ctl;
  logic [IW-1:0]          cmd_slot;
  logic [LW-1:0]          cmd_lvl;
  logic [COOKIE_BITS-1:0] cmd_cookie;
  logic                   o_valid, o_wv, o_last, o_err;
  logic [IW-1:0]          o_slot;
  logic [CW-1:0]          o_len;
  logic                   out_valid_r, out_wv_r, out_last_r, out_err_r;
  logic [IW-1:0]          out_slot_r;
  logic [CW-1:0]          out_len_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_priority_r <= MAXP_W'(RST_MAXP);
      batch_count_r <= BATCH_W'(RST_BATCH);
    end else if (cfg_we) begin
      case (cfg_idx_t'(cfg_index))
        CFG_MAXP:  max_priority_r <= cfg_wdata[MAXP_W-1:0];
        CFG_BATCH: batch_count_r <= cfg_wdata[BATCH_W-1:0];
        default:   max_priority_r <= max_priority_r;
      endcase
    end
  end

  pwqcb_front #(
    .MAX_TASKS(MAX_TASKS), .MAX_LEVEL(MAX_LEVEL), .COOKIE_BITS(COOKIE_BITS)
  ) u_front (
    .clk, .rst_n, .start, .busy,
    .in_action, .in_task_slot, .in_priority_req, .in_owner_cookie, .in_swapper,
    .max_priority(max_priority_r),
    .cmd_valid, .cmd_pop, .cmd_ctl, .cmd_slot, .cmd_lvl, .cmd_cookie
  );

  pwqcb_back #(
    .MAX_TASKS(MAX_TASKS), .MAX_LEVEL(MAX_LEVEL), .COOKIE_BITS(COOKIE_BITS)
  ) u_back (
    .clk, .rst_n,
    .max_priority(max_priority_r), .batch_count(batch_count_r),
    .cmd_valid, .cmd_pop, .cmd_ctl, .cmd_slot, .cmd_lvl, .cmd_cookie,
    .o_valid, .o_woken_valid(o_wv), .o_slot, .o_last, .o_error(o_err), .o_len
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= o_valid;
    end
  end

  always_ff @(posedge clk) begin
    out_wv_r <= o_wv;
    out_slot_r <= o_slot;
    out_last_r <= o_last;
    out_err_r <= o_err;
    out_len_r <= o_len;
  end

  assign out_valid        = out_valid_r;
  assign out_woken_valid  = out_wv_r;
  assign out_woken_slot   = SLOT_W'(out_slot_r);
  assign out_last         = out_last_r;
  assign out_error        = out_err_r;
  assign out_queue_length = LEN_W'(out_len_r);

endmodule

// ----- rtl/pwqcb_checker.sv -----
module pwqcb_checker import pwqcb_pkg::*; (
  input logic              clk,
  input logic              rst_n,
  input logic              out_valid,
  input logic              out_woken_valid,
  input logic [SLOT_W-1:0] out_woken_slot,
  input logic              out_last,
  input logic              out_error
);

  a_err_no_wake: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_error |-> !out_woken_valid && out_last)
    else $error("error beat also reports a woken task");

  a_empty_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_woken_valid |-> out_last)
    else $error("empty beat not marked last");

  a_empty_slot: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_woken_valid |-> out_woken_slot == '0)
    else $error("empty beat carries a slot");

endmodule

bind priority_wait_queue_cookie_batching pwqcb_checker u_pwqcb_checker (
  .clk, .rst_n, .out_valid, .out_woken_valid, .out_woken_slot, .out_last, .out_error
);

// ----- tb/sv/priority_wait_queue_cookie_batching_test.sv -----
`timescale 1ns / 100ps

module priority_wait_queue_cookie_batching_test;
  import pwqcb_pkg::*;

  localparam int NSLOT = 16;
  localparam int NLVL = 4;
  localparam int SETTLE = 40;

  typedef struct {
    logic       woken_valid;
    logic [3:0] woken_slot;
    logic       last;
    logic       error;
    logic [4:0] queue_length;
  } wake_report_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  action_t in_action = ACT_ENQ;
  logic [SLOT_W-1:0] in_task_slot = '0;
  logic [PRIO_W-1:0] in_priority_req = '0;
  logic [IN_COOKIE_W-1:0] in_owner_cookie = '0;
  logic in_swapper = 1'b0;
  logic out_valid;
  logic out_woken_valid;
  logic [SLOT_W-1:0] out_woken_slot;
  logic out_last;
  logic out_error;
  logic [LEN_W-1:0] out_queue_length;
  logic cfg_we = 1'b0;
  cfg_idx_t cfg_index = CFG_MAXP;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  priority_wait_queue_cookie_batching uut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_action(in_action), .in_task_slot(in_task_slot),
    .in_priority_req(in_priority_req), .in_owner_cookie(in_owner_cookie),
    .in_swapper(in_swapper), .out_valid(out_valid),
    .out_woken_valid(out_woken_valid), .out_woken_slot(out_woken_slot),
    .out_last(out_last), .out_error(out_error),
    .out_queue_length(out_queue_length),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // queue shadow state
  logic [1:0] max_prio;
  logic [7:0] batch_cnt;
  logic slot_queued [NSLOT];
  logic [1:0] slot_lvl [NSLOT];
  logic [15:0] slot_cookie [NSLOT];
  logic [3:0] slot_nxt [NSLOT];
  logic slot_has_nxt [NSLOT];
  logic slot_is_head [NSLOT];
  logic [3:0] grp_nxt [NSLOT];
  logic grp_has_nxt [NSLOT];
  logic [3:0] lvl_head [NLVL];
  logic [3:0] lvl_tail [NLVL];
  logic lvl_valid [NLVL];
  logic [1:0] cur_level;
  logic [15:0] cur_cookie;
  logic [7:0] batch_left;
  logic [6:0] level_credit;
  logic [4:0] queued_count;

  wake_report_t pending_reports[$];
  int fail_count = 0;
  int beats_sent = 0;
  int reports_seen = 0;
  bit idle_enable = 1'b1;

  function automatic void select_level(int l);
    cur_level = 2'(l);
    level_credit = 7'(1 << (2 * l));
  endfunction

  function automatic void select_cookie(logic [15:0] c);
    cur_cookie = c;
    batch_left = batch_cnt;
  endfunction

  function automatic void restart_scan();
    select_level(max_prio);
    select_cookie('0);
  endfunction

  function automatic void clear_queue();
    for (int i = 0; i < NSLOT; i++) begin
      slot_queued[i] = 0; slot_has_nxt[i] = 0; slot_is_head[i] = 0; grp_has_nxt[i] = 0;
      slot_lvl[i] = 0; slot_cookie[i] = 0; slot_nxt[i] = 0; grp_nxt[i] = 0;
    end
    for (int l = 0; l < NLVL; l++) begin
      lvl_valid[l] = 0; lvl_head[l] = 0; lvl_tail[l] = 0;
    end
    queued_count = 0;
    max_prio = 2'(RST_MAXP);
    batch_cnt = 8'(RST_BATCH);
    restart_scan();
  endfunction

  function automatic void append_group(int l, int s);
    slot_is_head[s] = 1;
    slot_has_nxt[s] = 0;
    if (lvl_valid[l]) begin
      slot_nxt[lvl_tail[l]] = 4'(s);
      slot_has_nxt[lvl_tail[l]] = 1;
    end else begin
      lvl_head[l] = 4'(s);
      lvl_valid[l] = 1;
    end
    lvl_tail[l] = 4'(s);
  endfunction

  function automatic void push_group_front(int l, int s);
    slot_is_head[s] = 1;
    if (lvl_valid[l]) begin
      slot_nxt[s] = lvl_head[l];
      slot_has_nxt[s] = 1;
    end else begin
      slot_has_nxt[s] = 0;
      lvl_tail[l] = 4'(s);
      lvl_valid[l] = 1;
    end
    lvl_head[l] = 4'(s);
  endfunction

  function automatic void rotate_level(int l);
    int h;
    h = lvl_head[l];
    if (!lvl_valid[l] || h == lvl_tail[l]) return;
    lvl_head[l] = slot_nxt[h];
    slot_has_nxt[h] = 0;
    slot_nxt[lvl_tail[l]] = 4'(h);
    slot_has_nxt[lvl_tail[l]] = 1;
    lvl_tail[l] = 4'(h);
  endfunction

  function automatic void unlink_slot(int s);
    int l, pred, m;
    l = slot_lvl[s];
    pred = -1;
    if (slot_is_head[s]) begin
      for (int q = 0; q < NSLOT; q++)
        if (slot_queued[q] && slot_is_head[q] && slot_has_nxt[q] && slot_nxt[q] == s)
          pred = q;
      if (grp_has_nxt[s]) begin
        m = grp_nxt[s];
        slot_is_head[m] = 1;
        slot_nxt[m] = slot_nxt[s];
        slot_has_nxt[m] = slot_has_nxt[s];
        if (pred < 0) lvl_head[l] = 4'(m);
        else slot_nxt[pred] = 4'(m);
        if (lvl_tail[l] == s) lvl_tail[l] = 4'(m);
      end else begin
        if (pred < 0) begin
          if (slot_has_nxt[s]) lvl_head[l] = slot_nxt[s];
          else lvl_valid[l] = 0;
        end else begin
          slot_nxt[pred] = slot_nxt[s];
          slot_has_nxt[pred] = slot_has_nxt[s];
        end
        if (lvl_tail[l] == s && pred >= 0) lvl_tail[l] = 4'(pred);
      end
    end else begin
      for (int q = 0; q < NSLOT; q++)
        if (slot_queued[q] && grp_has_nxt[q] && grp_nxt[q] == s) begin
          grp_nxt[q] = grp_nxt[s];
          grp_has_nxt[q] = grp_has_nxt[s];
        end
    end
    slot_queued[s] = 0;
    slot_is_head[s] = 0;
    slot_has_nxt[s] = 0;
    grp_has_nxt[s] = 0;
    queued_count = queued_count - 5'd1;
  endfunction

  function automatic bit enqueue_task(int s, int prio, logic [15:0] cookie, bit swp);
    int l, h, t;
    if (slot_queued[s]) return 1;
    slot_queued[s] = 1;
    slot_cookie[s] = cookie;
    grp_has_nxt[s] = 0;
    queued_count = queued_count + 5'd1;
    if (max_prio == 0) begin
      slot_lvl[s] = 0;
      if (swp) push_group_front(0, s);
      else append_group(0, s);
      return 0;
    end
    l = (prio > max_prio) ? max_prio : prio;
    slot_lvl[s] = 2'(l);
    if (lvl_valid[l]) begin
      h = lvl_head[l];
      for (int n = 0; n < NSLOT; n++) begin
        if (slot_cookie[h] == cookie) begin
          t = h;
          for (int k = 0; k < NSLOT && grp_has_nxt[t]; k++) t = grp_nxt[t];
          grp_nxt[t] = 4'(s);
          grp_has_nxt[t] = 1;
          slot_is_head[s] = 0;
          slot_has_nxt[s] = 0;
          return 0;
        end
        if (!slot_has_nxt[h]) break;
        h = slot_nxt[h];
      end
    end
    append_group(l, s);
    return 0;
  endfunction

  function automatic int choose_next();
    int lvl, q, t;
    lvl = cur_level;
    if (max_prio == 0) return lvl_valid[0] ? int'(lvl_head[0]) : -1;
    if (lvl_valid[lvl]) begin
      t = lvl_head[lvl];
      if (cur_cookie == slot_cookie[t]) begin
        batch_left = batch_left - 8'd1;
        if (batch_left != 0) return t;
        rotate_level(lvl);
      end
      level_credit = level_credit - 7'd1;
      if (level_credit != 0) begin
        select_cookie(slot_cookie[t]);
        return t;
      end
    end
    q = lvl;
    for (int i = 0; i < NLVL; i++) begin
      q = (q == 0) ? int'(max_prio) : q - 1;
      if (lvl_valid[q]) begin
        t = lvl_head[q];
        select_level(q);
        select_cookie(slot_cookie[t]);
        return t;
      end
      if (q == lvl) break;
    end
    restart_scan();
    return -1;
  endfunction

  function automatic void predict_wakeups(action_t act, int s, int prio,
                                          logic [15:0] cookie, bit swp);
    int woken[$];
    int t;
    bit err;
    wake_report_t r;
    err = 0;
    case (act)
      ACT_ENQ: err = enqueue_task(s, prio, cookie, swp);
      ACT_NEXT: begin
        t = choose_next();
        if (t >= 0) begin
          unlink_slot(t);
          woken.push_back(t);
        end
      end
      ACT_WAKE: begin
        if (slot_queued[s]) begin
          unlink_slot(s);
          woken.push_back(s);
        end
      end
      default: begin
        for (int l = NLVL - 1; l >= 0; l--)
          while (lvl_valid[l] && woken.size() < WALL_CAP) begin
            t = lvl_head[l];
            unlink_slot(t);
            woken.push_back(t);
          end
      end
    endcase
    if (woken.size() == 0) begin
      r = '{1'b0, 4'd0, 1'b1, err, queued_count};
      pending_reports.push_back(r);
    end
    foreach (woken[k]) begin
      r = '{1'b1, 4'(woken[k]), k == woken.size() - 1, 1'b0, queued_count};
      pending_reports.push_back(r);
    end
  endfunction

  always @(posedge clk) begin
    wake_report_t e;
    if (rst_n && out_valid) begin
      reports_seen++;
      if (pending_reports.size() == 0) begin
        $error("unexpected result: slot %0d valid %0d", out_woken_slot, out_woken_valid);
        fail_count++;
      end else begin
        e = pending_reports.pop_front();
        if (out_woken_valid !== e.woken_valid) begin
          $error("woken_valid: expected %0d, got %0d", e.woken_valid, out_woken_valid);
          fail_count++;
        end
        if (out_woken_slot !== e.woken_slot) begin
          $error("woken_slot: expected %0d, got %0d", e.woken_slot, out_woken_slot);
          fail_count++;
        end
        if (out_last !== e.last) begin
          $error("last: expected %0d, got %0d", e.last, out_last);
          fail_count++;
        end
        if (out_error !== e.error) begin
          $error("error: expected %0d, got %0d", e.error, out_error);
          fail_count++;
        end
        if (out_queue_length !== e.queue_length) begin
          $error("queue_length: expected %0d, got %0d", e.queue_length, out_queue_length);
          fail_count++;
        end
      end
    end
  end

  task automatic send_beat(action_t act, int s, int prio, logic [15:0] cookie, bit swp);
    start <= 1'b1;
    in_action <= act;
    in_task_slot <= 4'(s);
    in_priority_req <= 2'(prio);
    in_owner_cookie <= cookie;
    in_swapper <= swp;
    @(posedge clk);
    while (busy) @(posedge clk);
    predict_wakeups(act, s, prio, cookie, swp);
    beats_sent++;
  endtask

  task automatic maybe_idle();
    if (idle_enable && $urandom_range(0, 3) == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 16)) @(posedge clk);
    end
  endtask

  task automatic drain();
    start <= 1'b0;
    @(posedge clk);
    while (pending_reports.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_reg(cfg_idx_t idx, logic [7:0] value);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    @(posedge clk);
    if (idx == CFG_MAXP) max_prio = value[1:0];
    else batch_cnt = value;
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  task automatic test_empty_and_extremes();
    send_beat(ACT_NEXT, 0, 0, 16'h0000, 0);
    send_beat(ACT_WAKE, 15, 0, 16'h0000, 0);
    send_beat(ACT_ALL, 0, 0, 16'h0000, 0);
    drain();
    write_reg(CFG_MAXP, 8'd3);
    send_beat(ACT_ENQ, 0, 3, 16'hFFFF, 1);
    send_beat(ACT_ENQ, 15, 0, 16'h0000, 0);
    send_beat(ACT_ENQ, 0, 1, 16'h1234, 0);
    send_beat(ACT_ENQ, 5, 2, 16'hFFFF, 0);
    send_beat(ACT_ENQ, 6, 3, 16'hFFFF, 0);
    send_beat(ACT_NEXT, 0, 0, 16'h0000, 0);
    send_beat(ACT_WAKE, 6, 0, 16'h0000, 0);
    send_beat(ACT_ALL, 0, 0, 16'h0000, 0);
    drain();
  endtask

  task automatic test_plain_fifo();
    write_reg(CFG_MAXP, 8'd0);
    send_beat(ACT_ENQ, 1, 3, 16'h00AA, 0);
    send_beat(ACT_ENQ, 2, 2, 16'h00AA, 0);
    send_beat(ACT_ENQ, 3, 0, 16'h0055, 1);
    send_beat(ACT_NEXT, 0, 0, 16'h0000, 0);
    send_beat(ACT_NEXT, 0, 0, 16'h0000, 0);
    send_beat(ACT_NEXT, 0, 0, 16'h0000, 0);
    drain();
  endtask

  task automatic test_batch_rotation();
    write_reg(CFG_MAXP, 8'd1);
    write_reg(CFG_BATCH, 8'd2);
    for (int i = 0; i < 6; i++)
      send_beat(ACT_ENQ, i, 1, 16'(i % 2), 0);
    for (int i = 0; i < 3; i++)
      send_beat(ACT_NEXT, 0, 0, 16'h0000, 0);
    send_beat(ACT_WAKE, 1, 0, 16'h0000, 0);
    drain();
    write_reg(CFG_BATCH, 8'd0);
    for (int i = 0; i < 3; i++)
      send_beat(ACT_NEXT, 0, 0, 16'h0000, 0);
    drain();
  endtask

  task automatic test_register_change();
    write_reg(CFG_MAXP, 8'd3);
    send_beat(ACT_ENQ, 9, 3, 16'h0007, 0);
    send_beat(ACT_ENQ, 10, 0, 16'h0007, 0);
    drain();
    write_reg(CFG_MAXP, 8'd1);
    send_beat(ACT_NEXT, 0, 0, 16'h0000, 0);
    send_beat(ACT_ALL, 0, 0, 16'h0000, 0);
    drain();
  endtask

  task automatic test_random_phase(int maxp, int batch, int count, bit idle);
    int r;
    logic [15:0] cookie;
    action_t act;
    write_reg(CFG_MAXP, 8'(maxp));
    write_reg(CFG_BATCH, 8'(batch));
    idle_enable = idle;
    for (int i = 0; i < count; i++) begin
      r = $urandom_range(0, 99);
      if (r < 50) act = ACT_ENQ;
      else if (r < 82) act = ACT_NEXT;
      else if (r < 94) act = ACT_WAKE;
      else act = ACT_ALL;
      cookie = ($urandom_range(0, 4) == 0) ? 16'($urandom) : 16'($urandom_range(0, 3));
      send_beat(act, $urandom_range(0, 15), $urandom_range(0, 3), cookie, $urandom_range(0, 1));
      maybe_idle();
    end
    drain();
  endtask

  initial begin
    clear_queue();
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_empty_and_extremes();
    test_plain_fifo();
    test_batch_rotation();
    test_register_change();
    test_random_phase(2, 16, 50, 1);
    test_random_phase(0, 1, 50, 1);
    test_random_phase(3, 255, 50, 1);
    test_random_phase(1, 0, 40, 1);
    test_random_phase(3, 3, 50, 0);
    $display("Covered %0d commands and %0d wake reports over FIFO and multi-level modes,",
             beats_sent, reports_seen);
    $display("batch sizes 0 to 255, register changes with tasks waiting, duplicates.");
    if (fail_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("RESULT: ERROR");
    $finish;
  end

endmodule
